>>> hdl/rational_normalizer_defines.svh
// ----------------------------------------------------------------------------
// Rational normaliser assertion macros
// Shared concurrent assertion forms for the rational normaliser checker.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_NORMALIZER_DEFINES_SVH
`define RATIONAL_NORMALIZER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define RN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rn_pkg.sv
// ----------------------------------------------------------------------------
// Rational normaliser package
// Shared default data width and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package rn_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD_GO,
    ST_GCD_WAIT,
    ST_NUM_GO,
    ST_NUM_WAIT,
    ST_DEN_GO,
    ST_DEN_WAIT
  } rn_state_e;

endpackage

`default_nettype wire

>>> hdl/rn_divider.sv
// ----------------------------------------------------------------------------
// Rational normaliser divider
// Restoring unsigned divider, one quotient bit per cycle; gives quotient and
// remainder and pulses done for one cycle when finished.
// ----------------------------------------------------------------------------
`default_nettype none

module rn_divider #(
  parameter int unsigned Width = rn_pkg::DATA_WIDTH_DEF - 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             go_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic      [Width-1:0] quotient_o,
  output logic      [Width-1:0] remainder_o,
  output logic                  done_o
);

  localparam int unsigned CntW = $clog2(Width);

  logic [Width-1:0] quo_q, quo_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [Width:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[Width-1]} - {1'b0, dvs_q};
    if (go_i && !run_q) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CntW'(Width - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-2:0], quo_q[Width-1]};
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

>>> hdl/rational_normalizer.sv
// ----------------------------------------------------------------------------
// Rational normaliser
// Reduces a signed fraction to lowest terms: Euclid's remainder loop on the
// magnitudes, then both magnitudes divided by the GCD, sign reapplied.
// ----------------------------------------------------------------------------
// Timing: a word is taken when start is high and busy is low. A zero
// numerator or zero denominator gives its 0/1 result in the next cycle with
// busy staying low. Otherwise busy rises and stays high until the result
// appears, and the next word can be taken once busy is low again. Each Euclid
// remainder step (1 up to about 1.44 * DATA_WIDTH of them) and both final
// divisions run through the one bit-serial divider, one quotient bit a cycle.
// Each result is shown for one cycle with valid_o high and must be taken
// then; the receiver cannot stall it. busy falls in the cycle the result
// appears.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_normalizer #(
  parameter int unsigned DATA_WIDTH = rn_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] num_in_i,
  input  wire logic signed [DATA_WIDTH-1:0] den_in_i,
  output logic                              valid_o,
  output logic signed      [DATA_WIDTH-1:0] num_out_o,
  output logic             [DATA_WIDTH-2:0] den_out_o,
  output logic                              zero_den_error_o
);

  localparam int unsigned MagW = DATA_WIDTH - 1;

  rn_pkg::rn_state_e state_q, state_d;

  logic [MagW-1:0]       a_q, a_d;
  logic [MagW-1:0]       b_q, b_d;
  logic [MagW-1:0]       nmag_q, nmag_d;
  logic [MagW-1:0]       dmag_q, dmag_d;
  logic                  neg_q, neg_d;
  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] num_out_q, num_out_d;
  logic [MagW-1:0]       den_out_q, den_out_d;
  logic                  err_q, err_d;

  logic [DATA_WIDTH-1:0] num_abs, den_abs;
  logic [MagW-1:0]       num_mag, den_mag;

  logic                  div_go;
  logic [MagW-1:0]       div_a, div_b;
  logic [MagW-1:0]       div_quo, div_rem;
  logic                  div_done;

  // Magnitudes, saturating the most negative code.
  always_comb begin
    num_abs = num_in_i[DATA_WIDTH-1] ? (~num_in_i + 1'b1) : num_in_i;
    den_abs = den_in_i[DATA_WIDTH-1] ? (~den_in_i + 1'b1) : den_in_i;
    num_mag = num_abs[DATA_WIDTH-1] ? '1 : num_abs[MagW-1:0];
    den_mag = den_abs[DATA_WIDTH-1] ? '1 : den_abs[MagW-1:0];
  end

  rn_divider #(
    .Width(MagW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quotient_o (div_quo),
    .remainder_o(div_rem),
    .done_o     (div_done)
  );

  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    b_d       = b_q;
    nmag_d    = nmag_q;
    dmag_d    = dmag_q;
    neg_d     = neg_q;
    valid_d   = 1'b0;
    num_out_d = num_out_q;
    den_out_d = den_out_q;
    err_d     = err_q;
    div_go    = 1'b0;
    div_a     = a_q;
    div_b     = b_q;
    case (state_q)
      rn_pkg::ST_IDLE: begin
        if (start) begin
          neg_d = num_in_i[DATA_WIDTH-1] ^ den_in_i[DATA_WIDTH-1];
          if (den_mag == '0) begin
            valid_d   = 1'b1;
            num_out_d = '0;
            den_out_d = MagW'(1);
            err_d     = 1'b1;
          end else if (num_mag == '0) begin
            valid_d   = 1'b1;
            num_out_d = '0;
            den_out_d = MagW'(1);
            err_d     = 1'b0;
          end else begin
            a_d     = num_mag;
            b_d     = den_mag;
            nmag_d  = num_mag;
            dmag_d  = den_mag;
            state_d = rn_pkg::ST_GCD_GO;
          end
        end
      end
      rn_pkg::ST_GCD_GO: begin
        div_go  = 1'b1;
        state_d = rn_pkg::ST_GCD_WAIT;
      end
      rn_pkg::ST_GCD_WAIT: begin
        if (div_done) begin
          a_d = b_q;
          b_d = div_rem;
          if (div_rem == '0) begin
            state_d = rn_pkg::ST_NUM_GO;
          end else begin
            state_d = rn_pkg::ST_GCD_GO;
          end
        end
      end
      rn_pkg::ST_NUM_GO: begin
        div_go  = 1'b1;
        div_a   = nmag_q;
        div_b   = a_q;
        state_d = rn_pkg::ST_NUM_WAIT;
      end
      rn_pkg::ST_NUM_WAIT: begin
        if (div_done) begin
          nmag_d  = div_quo;
          state_d = rn_pkg::ST_DEN_GO;
        end
      end
      rn_pkg::ST_DEN_GO: begin
        div_go  = 1'b1;
        div_a   = dmag_q;
        div_b   = a_q;
        state_d = rn_pkg::ST_DEN_WAIT;
      end
      rn_pkg::ST_DEN_WAIT: begin
        if (div_done) begin
          valid_d   = 1'b1;
          num_out_d = neg_q ? (~{1'b0, nmag_q} + 1'b1) : {1'b0, nmag_q};
          den_out_d = div_quo;
          err_d     = 1'b0;
          state_d   = rn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rn_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    nmag_q    <= nmag_d;
    dmag_q    <= dmag_d;
    neg_q     <= neg_d;
    num_out_q <= num_out_d;
    den_out_q <= den_out_d;
    err_q     <= err_d;
  end

  assign busy             = (state_q != rn_pkg::ST_IDLE);
  assign valid_o          = valid_q;
  assign num_out_o        = num_out_q;
  assign den_out_o        = den_out_q;
  assign zero_den_error_o = err_q;

endmodule

`default_nettype wire

>>> hdl/rn_checker.sv
// ----------------------------------------------------------------------------
// Rational normaliser checker
// Port-level assertions on results and busy, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rational_normalizer_defines.svh"

module rn_checker #(
  parameter int unsigned DATA_WIDTH = rn_pkg::DATA_WIDTH_DEF
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic signed [DATA_WIDTH-1:0] den_in_i,
  input wire logic                         valid_o,
  input wire logic signed [DATA_WIDTH-1:0] num_out_o,
  input wire logic        [DATA_WIDTH-2:0] den_out_o,
  input wire logic                         zero_den_error_o
);

  `RN_ASSERT_NEXT(a_zero_den, clk_i, rst_ni, start && !busy && den_in_i == '0, valid_o && zero_den_error_o, "zero denominator not flagged next cycle")
  `RN_ASSERT_SAME(a_err_value, clk_i, rst_ni, valid_o && zero_den_error_o, num_out_o == '0 && den_out_o == 1, "error word is not 0/1")
  `RN_ASSERT_SAME(a_den_pos, clk_i, rst_ni, valid_o, den_out_o != '0, "zero denominator in result")
  `RN_ASSERT_SAME(a_busy_fall, clk_i, rst_ni, $fell(busy), valid_o, "busy fell without a result")

endmodule

bind rational_normalizer rn_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_rn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .den_in_i        (den_in_i),
  .valid_o         (valid_o),
  .num_out_o       (num_out_o),
  .den_out_o       (den_out_o),
  .zero_den_error_o(zero_den_error_o)
);

`default_nettype wire

>>> test/rational_normalizer_tb.sv
// ----------------------------------------------------------------------------
// Rational normaliser testbench
// Drives signed fractions into the normaliser, predicts each reduced word
// (sign, GCD reduction, zero numerator and zero denominator cases) and checks
// every strobed result in order against the prediction.
// ----------------------------------------------------------------------------
module rational_normalizer_tb;

  localparam int unsigned DW = rn_pkg::DATA_WIDTH_DEF;
  localparam logic signed [DW-1:0] MAX_POS  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASE_WORDS = 445;

  typedef struct {
    logic signed [DW-1:0] num;
    logic        [DW-2:0] den;
    logic                 err;
  } ratio_t;

  class reduced_ratio_board;
    ratio_t pending_ratios[$];
    int     mismatches;

    function new();
      mismatches = 0;
    endfunction

    function ratio_t reduce_fraction(logic signed [DW-1:0] n, logic signed [DW-1:0] d);
      ratio_t     r;
      logic [DW-1:0] nm, dm, a, b, t;
      logic       nneg, dneg;
      nneg = n[DW-1];
      dneg = d[DW-1];
      nm = nneg ? (~n + 1'b1) : n;
      dm = dneg ? (~d + 1'b1) : d;
      // most negative value saturates to the largest magnitude
      if (nm > MAX_POS) nm = MAX_POS;
      if (dm > MAX_POS) dm = MAX_POS;
      r.num = '0;
      r.den = 1;
      r.err = 1'b0;
      if (dm == 0) begin
        r.err = 1'b1;
      end else if (nm != 0) begin
        a = nm;
        b = dm;
        while (b != 0) begin
          t = a % b;
          a = b;
          b = t;
        end
        nm = nm / a;
        dm = dm / a;
        r.num = (nneg != dneg) ? -nm : nm;
        r.den = dm[DW-2:0];
      end
      return r;
    endfunction

    function void note_word(logic signed [DW-1:0] n, logic signed [DW-1:0] d);
      pending_ratios.push_back(reduce_fraction(n, d));
    endfunction

    function void check_word(logic signed [DW-1:0] n, logic [DW-2:0] d, logic e);
      ratio_t want;
      if (pending_ratios.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: got %0d/%0d err %0b", n, d, e);
        return;
      end
      want = pending_ratios.pop_front();
      if (want.num !== n || want.den !== d || want.err !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b",
                   want.num, want.den, want.err, n, d, e);
      end
    endfunction

    function int pending();
      return pending_ratios.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [DW-1:0] num_in;
  logic signed [DW-1:0] den_in;
  logic                 valid;
  logic signed [DW-1:0] num_out;
  logic        [DW-2:0] den_out;
  logic                 zero_den_error;

  reduced_ratio_board board = new();
  int unsigned        stall_cycles;

  rational_normalizer #(
    .DATA_WIDTH(DW)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .num_in_i        (num_in),
    .den_in_i        (den_in),
    .valid_o         (valid),
    .num_out_o       (num_out),
    .den_out_o       (den_out),
    .zero_den_error_o(zero_den_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result first: a word taken on the same edge is younger
  always @(posedge clk) begin
    if (rst_n) begin
      if (valid) board.check_word(num_out, den_out, zero_den_error);
      if (start && !busy) board.note_word(num_in, den_in);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || valid || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic put_word(logic signed [DW-1:0] n, logic signed [DW-1:0] d);
    start  <= 1'b1;
    num_in <= n;
    den_in <= d;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic rest(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] any_word();
    logic signed [DW-1:0] w;
    do w = $urandom; while (w == MOST_NEG);
    return w;
  endfunction

  function automatic logic signed [DW-1:0] signed_mag(logic [DW-1:0] mag);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic pick_pair(output logic signed [DW-1:0] n, output logic signed [DW-1:0] d);
    int unsigned sel, f;
    sel = $urandom_range(0, 99);
    f   = $urandom_range(2, 4000);
    if (sel < 40) begin
      n = any_word();
      d = any_word();
    end else if (sel < 65) begin
      n = signed_mag($urandom_range(1, 300));
      d = signed_mag($urandom_range(1, 300));
    end else if (sel < 85) begin
      // shared factor
      n = signed_mag($urandom_range(1, 20000) * f);
      d = signed_mag($urandom_range(1, 20000) * f);
    end else if (sel < 92) begin
      n = '0;
      d = $urandom_range(0, 1) ? any_word() : signed_mag($urandom_range(1, 50));
    end else if (sel < 98) begin
      n = $urandom_range(0, 1) ? any_word() : '0;
      d = '0;
    end else begin
      n = any_word();
      d = $urandom_range(0, 1) ? n : -n;
    end
  endtask

  initial begin
    logic signed [DW-1:0] n, d;
    int unsigned          idle_pct;
    rst_n  = 1'b0;
    start  = 1'b0;
    num_in = '0;
    den_in = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_word(0, 5);
    put_word(0, -7);
    put_word(5, 0);
    put_word(-12, 0);
    put_word(0, 0);
    put_word(MAX_POS, 0);
    put_word(MAX_POS, MAX_POS);
    put_word(-MAX_POS, MAX_POS);
    put_word(MAX_POS, -MAX_POS);
    put_word(-MAX_POS, -MAX_POS);
    put_word(1, MAX_POS);
    put_word(MAX_POS, 1);
    put_word(-1, -1);
    put_word(1, 1);
    put_word(6, 4);
    put_word(-6, 4);
    put_word(6, -4);
    put_word(-6, -4);
    put_word(12, 18);
    put_word(7, 49);
    put_word(32'sd1073741824, 32'sd536870912);
    // consecutive Fibonacci numbers: longest remainder chain
    put_word(32'sd1836311903, 32'sd1134903170);
    put_word(-32'sd1134903170, 32'sd1836311903);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 24 : (phase == 1) ? 62 : 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 99) < idle_pct) rest($urandom_range(1, 6));
        pick_pair(n, d);
        put_word(n, d);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/rn_pkg.sv
hdl/rn_divider.sv
hdl/rational_normalizer.sv
hdl/rn_checker.sv
test/rational_normalizer_tb.sv
